/* rtl/nearest_texture_sampler_macros.svh */
// Assertion macros for the nearest texture sampler.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_TEXTURE_SAMPLER_MACROS_SVH
`define NEAREST_TEXTURE_SAMPLER_MACROS_SVH

// same-cycle implication, off during reset
`define NTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define NTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nts_pkg.sv */
// Shared types, codes and the coordinate wrap function of the texture sampler.
// No dependencies.
`default_nettype none

package nts_pkg;

    localparam int COORD_W    = 24;
    localparam int UNIT_W     = 17;
    localparam int INDEX_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [UNIT_W-1:0] unit_t;

    localparam unit_t      ONE_Q16      = 17'h10000;
    localparam unit_t      HALF_Q16     = 17'h08000;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;

    localparam logic FILTER_NEAREST = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNIFY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_M1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_M1 = 3'd4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } texel_t;

    typedef struct packed {
        logic [1:0] wrap_x;
        logic [1:0] wrap_y;
        logic       magnify;
        logic [7:0] width_m1;
        logic [7:0] height_m1;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic load;
    } pipe_ctl_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        texel_t             texel;
        logic [7:0]         xi;
        logic [7:0]         yi;
    } scaled_t;

    function automatic unit_t wrap_coord(input logic [COORD_W-1:0] raw,
                                         input logic [1:0] mode);
        logic  in_unit;
        unit_t res;
        in_unit = !raw[COORD_W-1] && (raw[COORD_W-2:0] <= 23'(ONE_Q16));
        if (in_unit)
        begin
            res = raw[UNIT_W-1:0];
        end
        else
        begin
            unique case (mode)
                WRAP_REPEAT: res = {1'b0, raw[15:0]};
                WRAP_CLAMP:  res = raw[COORD_W-1] ? '0 : ONE_Q16;
                default:     res = '0;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/nts_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module nts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/nts_coord.sv */
// Coordinate stages: wrap and flip (stage A), scale and round to texel (stage B).
// Depends on nts_pkg.
`default_nettype none

module nts_coord (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire nts_pkg::cfg_t                  cfg,
    input  wire logic                           in_fire,
    input  wire logic                           in_kind,
    input  wire logic [nts_pkg::INDEX_W-1:0]    in_index,
    input  wire nts_pkg::texel_t                in_texel,
    input  wire logic [nts_pkg::COORD_W-1:0]    in_u,
    input  wire logic [nts_pkg::COORD_W-1:0]    in_v,
    output nts_pkg::pipe_ctl_t                  out_ctl,
    output nts_pkg::scaled_t                    out_word
);
    import nts_pkg::*;

    pipe_ctl_t          a_ctl_next;
    pipe_ctl_t          a_ctl_reg;
    logic [INDEX_W-1:0] a_index_reg;
    texel_t             a_texel_reg;
    unit_t              a_u_next;
    unit_t              a_u_reg;
    unit_t              a_v_next;
    unit_t              a_v_reg;
    logic [24:0]        x_scaled;
    logic [24:0]        y_scaled;
    pipe_ctl_t          b_ctl_reg;
    scaled_t            b_word_next;
    scaled_t            b_word_reg;

    // drop samples when the magnifying filter is not nearest
    always_comb
    begin
        a_ctl_next.valid = in_fire
                           && (in_kind == KIND_LOAD || cfg.magnify == FILTER_NEAREST);
        a_ctl_next.load  = (in_kind == KIND_LOAD);
        a_u_next         = wrap_coord(in_u, cfg.wrap_x);
        a_v_next         = ONE_Q16 - wrap_coord(in_v, cfg.wrap_y);
    end

    always_comb
    begin
        x_scaled          = 25'(cfg.width_m1) * 25'(a_u_reg) + 25'(HALF_Q16);
        y_scaled          = 25'(cfg.height_m1) * 25'(a_v_reg) + 25'(HALF_Q16);
        b_word_next.index = a_index_reg;
        b_word_next.texel = a_texel_reg;
        b_word_next.xi    = x_scaled[23:16];
        b_word_next.yi    = y_scaled[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
        end
        else if (adv)
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_index_reg <= in_index;
            a_texel_reg <= in_texel;
            a_u_reg     <= a_u_next;
            a_v_reg     <= a_v_next;
            b_word_reg  <= b_word_next;
        end
    end

    assign out_ctl  = b_ctl_reg;
    assign out_word = b_word_reg;

endmodule

`default_nettype wire

/* rtl/nts_addr.sv */
// Address stages: row-major linearise (C), reciprocal quotient (D), remainder (E).
// Depends on nts_pkg.
`default_nettype none

module nts_addr #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   adv,
    input  wire nts_pkg::cfg_t                          cfg,
    input  wire nts_pkg::pipe_ctl_t                     in_ctl,
    input  wire nts_pkg::scaled_t                       in_word,
    output nts_pkg::pipe_ctl_t                          out_ctl,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]        out_addr,
    output nts_pkg::texel_t                             out_texel
);
    import nts_pkg::*;

    localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int          ADDR_W = $clog2(DEPTH);
    localparam bit          REDUCE = (DEPTH < (1 << INDEX_W));

    logic [8:0]         stride;
    logic [16:0]        row_base;
    logic [INDEX_W-1:0] c_addr_next;
    pipe_ctl_t          c_ctl_reg;
    logic [INDEX_W-1:0] c_addr_reg;
    texel_t             c_texel_reg;
    pipe_ctl_t          d_ctl_reg;
    logic [INDEX_W-1:0] d_addr_reg;
    texel_t             d_texel_reg;
    logic [ADDR_W-1:0]  e_addr_next;
    pipe_ctl_t          e_ctl_reg;
    logic [ADDR_W-1:0]  e_addr_reg;
    texel_t             e_texel_reg;

    always_comb
    begin
        stride      = {1'b0, cfg.width_m1} + 9'd1;
        row_base    = 17'(in_word.yi) * 17'(stride) + 17'(in_word.xi);
        c_addr_next = in_ctl.load ? in_word.index : row_base[INDEX_W-1:0];
    end

    generate
        if (REDUCE)
        begin : g_mod
            localparam longint unsigned RECIP_L = ((64'd1 << 32) + DEPTH - 1) / DEPTH;
            localparam logic [31:0]     RECIP   = 32'(RECIP_L);

            logic [47:0]        quot_prod;
            logic [INDEX_W-1:0] quot_reg;
            logic [31:0]        back_prod;
            logic [INDEX_W-1:0] rem;

            // quotient is exact for a 16-bit dividend with a rounded-up reciprocal
            assign quot_prod = 48'(c_addr_reg) * 48'(RECIP);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    quot_reg <= quot_prod[47:32];
                end
            end

            assign back_prod   = 32'(quot_reg) * 32'(DEPTH);
            assign rem         = d_addr_reg - back_prod[INDEX_W-1:0];
            assign e_addr_next = rem[ADDR_W-1:0];
        end
        else
        begin : g_wide
            assign e_addr_next = ADDR_W'(d_addr_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
            e_ctl_reg <= '0;
        end
        else if (adv)
        begin
            c_ctl_reg <= in_ctl;
            d_ctl_reg <= c_ctl_reg;
            e_ctl_reg <= d_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_addr_reg  <= c_addr_next;
            c_texel_reg <= in_word.texel;
            d_addr_reg  <= c_addr_reg;
            d_texel_reg <= c_texel_reg;
            e_addr_reg  <= e_addr_next;
            e_texel_reg <= d_texel_reg;
        end
    end

    assign out_ctl   = e_ctl_reg;
    assign out_addr  = e_addr_reg;
    assign out_texel = e_texel_reg;

endmodule

`default_nettype wire

/* rtl/nearest_texture_sampler.sv */
// Top level of the nearest texture sampler: config registers, texel RAM, output word.
// Depends on nts_pkg, nts_coord, nts_addr, nts_ram and the assertion macro header.
//
//  port group      dir  width         content
//  s_t*            in   88 + 1        load or sample word, kind on s_tuser
//  m_t*            out  32            sampled RGBA word
//  cfg_*           in   3 + 8         register write, no read-back
//
// One word is accepted per cycle while the output word is not held; a sample word
// reaches the output through six register stages and the registered RAM read.
// Each cycle takes at most one RAM access: a load writes, a sample reads.
// A held output word stalls every stage at once; nothing is lost or repeated.
// Reset clears the valid bits and sets the config registers to their defaults; the texel RAM is not cleared.
`default_nettype none
`include "nearest_texture_sampler_macros.svh"

module nearest_texture_sampler #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // texel_index, load_red, load_green, load_blue, u_coord, v_coord
    input  wire logic [87:0]                      s_tdata,
    // kind
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // red, green, blue, alpha
    output logic [31:0]                           m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [nts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nts_pkg::*;

    localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int          ADDR_W = $clog2(DEPTH);

    cfg_t              cfg_reg;
    logic              adv;
    logic              in_fire;
    texel_t            in_texel;
    pipe_ctl_t         b_ctl;
    scaled_t           b_word;
    pipe_ctl_t         e_ctl;
    logic [ADDR_W-1:0] e_addr;
    texel_t            e_texel;
    logic              ram_we;
    logic              ram_re;
    logic [23:0]       ram_rdata;
    texel_t            rd_texel;
    logic              f_valid_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign in_fire  = s_tvalid && s_tready;

    assign in_texel.red   = s_tdata[23:16];
    assign in_texel.green = s_tdata[31:24];
    assign in_texel.blue  = s_tdata[39:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_x    <= WRAP_REPEAT;
            cfg_reg.wrap_y    <= WRAP_REPEAT;
            cfg_reg.magnify   <= FILTER_NEAREST;
            cfg_reg.width_m1  <= 8'd255;
            cfg_reg.height_m1 <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WRAP_X:    cfg_reg.wrap_x    <= cfg_data[1:0];
                CFG_WRAP_Y:    cfg_reg.wrap_y    <= cfg_data[1:0];
                CFG_MAGNIFY:   cfg_reg.magnify   <= cfg_data[0];
                CFG_WIDTH_M1:  cfg_reg.width_m1  <= cfg_data;
                CFG_HEIGHT_M1: cfg_reg.height_m1 <= cfg_data;
                default:       ;
            endcase
        end
    end

    nts_coord u_coord (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_fire  (in_fire),
        .in_kind  (s_tuser),
        .in_index (s_tdata[15:0]),
        .in_texel (in_texel),
        .in_u     (s_tdata[63:40]),
        .in_v     (s_tdata[87:64]),
        .out_ctl  (b_ctl),
        .out_word (b_word)
    );

    nts_addr #(
        .MAX_SIDE (MAX_SIDE)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_ctl    (b_ctl),
        .in_word   (b_word),
        .out_ctl   (e_ctl),
        .out_addr  (e_addr),
        .out_texel (e_texel)
    );

    assign ram_we = adv && e_ctl.valid && e_ctl.load;
    assign ram_re = adv && e_ctl.valid && !e_ctl.load;

    nts_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (e_addr),
        .wdata (e_texel),
        .re    (ram_re),
        .raddr (e_addr),
        .rdata (ram_rdata)
    );

    assign rd_texel = texel_t'(ram_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg   <= e_ctl.valid && !e_ctl.load;
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {ALPHA_OPAQUE, rd_texel.blue, rd_texel.green, rd_texel.red};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `NTS_ASSERT_SAME(a_addr_in_store, e_ctl.valid, 32'(e_addr) < 32'(DEPTH),
        "texel address beyond store depth")
    `NTS_ASSERT_NEXT(a_load_no_result, adv && e_ctl.valid && e_ctl.load, !f_valid_reg,
        "load word produced a result")
    `NTS_ASSERT_SAME(a_one_ram_access, ram_we || ram_re, !(ram_we && ram_re),
        "RAM written and read in one cycle")

endmodule

`default_nettype wire
